// ===== sv/wsa_pkg.sv =====
// Shared types, constants and helpers of the weighted strategy averager.
package wsa_pkg;

    localparam int MAX_COMBOS  = 2048;
    localparam int MAX_ACTIONS = 8;
    localparam int COMBO_W     = $clog2(MAX_COMBOS);
    localparam int ACTION_W    = $clog2(MAX_ACTIONS);
    localparam int SLOT_W      = COMBO_W + ACTION_W;
    localparam int SLOT_DEPTH  = MAX_COMBOS * MAX_ACTIONS;
    localparam int CLR_W       = SLOT_W + 1;
    localparam int SUM_W       = 64;
    localparam int PROB_W      = 17;
    localparam int WEFF_W      = 48;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

    localparam logic [1:0] OP_PLAIN      = 2'd0;
    localparam logic [1:0] OP_IMPORTANCE = 2'd1;
    localparam logic [1:0] OP_DELAYED    = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_SKIP   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [1:0] CFG_ACTIONS = 2'd0;
    localparam logic [1:0] CFG_COMBOS  = 2'd1;
    localparam logic [1:0] CFG_DELAY   = 2'd2;

    typedef struct packed {
        logic [3:0]  actions_in_use;
        logic [11:0] combos_in_use;
        logic [31:0] delay_iterations;
    } wsa_cfg_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [1:0]          opcode;
        logic [COMBO_W-1:0]  combo_index;
        logic [ACTION_W-1:0] action_index;
        logic [PROB_W-1:0]   strategy_prob;
        logic [PROB_W-1:0]   reach_prob;
        logic [WEFF_W-1:0]   eff_weight;
        logic [PROB_W-1:0]   uniform_prob;
    } wsa_job_t;

    // floor(1.0 / actions) in Q1.16
    function automatic logic [PROB_W-1:0] uniform_q16(input logic [3:0] actions);
        logic [PROB_W-1:0] u;
        begin
            case (actions)
                4'd1:    u = PROB_W'(65536);
                4'd2:    u = PROB_W'(32768);
                4'd3:    u = PROB_W'(21845);
                4'd4:    u = PROB_W'(16384);
                4'd5:    u = PROB_W'(13107);
                4'd6:    u = PROB_W'(10922);
                4'd7:    u = PROB_W'(9362);
                4'd8:    u = PROB_W'(8192);
                default: u = '0;
            endcase
            return u;
        end
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[SUM_W] ? '1 : s[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== sv/wsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/wsa_front.sv =====
// Front end: accepts items, checks them, forms the effective weight.
module wsa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  wsa_pkg::wsa_cfg_t   cfg,
    input  logic                clearing,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [135:0]        s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                push_valid,
    input  logic                push_ready,
    output wsa_pkg::wsa_job_t   push_job
);
    import wsa_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    wsa_job_t          job_reg, job_next;
    logic [PROB_W-1:0] samp_reg, samp_next;
    logic [16:0]       rem_reg, rem_next;
    logic [WEFF_W-1:0] quo_reg, quo_next;
    logic [5:0]        cnt_reg, cnt_next;

    logic [1:0]          op;
    logic [COMBO_W-1:0]  combo;
    logic [ACTION_W-1:0] action;
    logic [PROB_W-1:0]   sprob, rprob, samp;
    logic [31:0]         weight, iter;
    logic                bad_cfg, bad_index, bad_prob;
    logic [1:0]          status;
    logic                need_div;
    logic [31:0]         iter_diff;
    logic [17:0]         rem_sh;

    assign op     = s_tuser;
    assign combo  = s_tdata[10:0];
    assign action = s_tdata[13:11];
    assign sprob  = s_tdata[30:14];
    assign rprob  = s_tdata[47:31];
    assign weight = s_tdata[79:48];
    assign samp   = s_tdata[96:80];
    assign iter   = s_tdata[128:97];

    assign iter_diff = iter - cfg.delay_iterations;
    assign bad_cfg   = (cfg.actions_in_use == 4'd0) || (cfg.actions_in_use > 4'(MAX_ACTIONS))
                    || (cfg.combos_in_use == 12'd0) || (cfg.combos_in_use > 12'(MAX_COMBOS));
    assign bad_index = ({1'b0, combo} >= cfg.combos_in_use)
                    || ({1'b0, action} >= cfg.actions_in_use);
    assign bad_prob  = (sprob > ONE_Q16) || (rprob > ONE_Q16);

    always_comb
    begin
        status   = ST_DONE;
        need_div = 1'b0;
        if (op == OP_DELAYED && iter == 32'd0)
            status = ST_REJECT;
        else if (op == OP_DELAYED && iter <= cfg.delay_iterations)
            status = ST_SKIP;
        else if (bad_cfg || bad_index)
            status = ST_REJECT;
        else if (op != OP_READ && bad_prob)
            status = ST_REJECT;
        else if (op == OP_IMPORTANCE && (samp == '0 || samp > ONE_Q16))
            status = ST_REJECT;
        else if (op == OP_IMPORTANCE)
            need_div = 1'b1;
    end

    assign rem_sh = {rem_reg, quo_reg[WEFF_W-1]};

    assign s_tready   = (state_reg == F_IDLE) && !clearing;
    assign push_valid = (state_reg == F_PUSH);
    assign push_job   = job_reg;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        samp_next  = samp_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    job_next.status        = status;
                    job_next.opcode        = op;
                    job_next.combo_index   = combo;
                    job_next.action_index  = action;
                    job_next.strategy_prob = sprob;
                    job_next.reach_prob    = rprob;
                    job_next.uniform_prob  = uniform_q16(cfg.actions_in_use);
                    if (op == OP_DELAYED)
                        job_next.eff_weight = {iter_diff, 16'd0};
                    else
                        job_next.eff_weight = {16'd0, weight};
                    samp_next = samp;
                    rem_next  = '0;
                    quo_next  = {weight, 16'd0};
                    cnt_next  = 6'(WEFF_W);
                    state_next = need_div ? F_DIV : F_PUSH;
                end
            end
            F_DIV:
            begin
                // one quotient bit per cycle, restoring
                if (rem_sh >= {1'b0, samp_reg})
                begin
                    rem_next = 17'(rem_sh - {1'b0, samp_reg});
                    quo_next = {quo_reg[WEFF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[16:0];
                    quo_next = {quo_reg[WEFF_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    job_next.eff_weight = quo_next;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        samp_reg <= samp_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end
endmodule

// ===== sv/wsa_queue.sv =====
// Short job queue between the front end and the back end.
module wsa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  wsa_pkg::wsa_job_t  push_job,
    output logic               pop_valid,
    input  logic               pop_ready,
    output wsa_pkg::wsa_job_t  pop_job
);
    import wsa_pkg::*;

    wsa_job_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end
endmodule

// ===== sv/wsa_back.sv =====
// Back end: read-modify-write of the sums, finalize division, result register.
module wsa_back (
    input  logic               clk,
    input  logic               rst_n,
    output logic               clearing,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  wsa_pkg::wsa_job_t  pop_job,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import wsa_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RD   = 3'd1;
    localparam logic [2:0] B_MUL1 = 3'd2;
    localparam logic [2:0] B_MUL2 = 3'd3;
    localparam logic [2:0] B_WR   = 3'd4;
    localparam logic [2:0] B_DIV  = 3'd5;
    localparam logic [2:0] B_FIN  = 3'd6;

    localparam int ACC_W = SUM_W + PROB_W;

    logic [2:0]        state_reg, state_next;
    logic [CLR_W-1:0]  clr_reg, clr_next;
    wsa_job_t          job_reg, job_next;
    logic [SUM_W-1:0]  ws_reg, ws_next;
    logic [SUM_W-1:0]  rs_reg, rs_next;
    logic [SUM_W-1:0]  p_reg, p_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [PROB_W-1:0] mplier_reg, mplier_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [15:0]       quo_reg, quo_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [PROB_W-1:0] res_avg_reg, res_avg_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [PROB_W-1:0] out_avg_reg, out_avg_next;

    logic              ws_we, rs_we;
    logic [SLOT_W-1:0] ws_waddr, ws_raddr;
    logic [COMBO_W-1:0] rs_waddr;
    logic [SUM_W-1:0]  ws_wdata, rs_wdata, ws_rdata, rs_rdata;
    logic [SUM_W:0]    rem_sh;

    assign clearing  = !clr_reg[CLR_W-1];
    assign pop_ready = (state_reg == B_IDLE) && !clearing;
    assign ws_raddr  = {pop_job.combo_index, pop_job.action_index};
    assign rem_sh    = {rem_reg, 1'b0};

    wsa_ram #(.WIDTH(SUM_W), .DEPTH(SLOT_DEPTH)) u_weighted (
        .clk   (clk),
        .we    (ws_we),
        .waddr (ws_waddr),
        .wdata (ws_wdata),
        .raddr (ws_raddr),
        .rdata (ws_rdata)
    );

    wsa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COMBOS)) u_reach (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata (rs_wdata),
        .raddr (pop_job.combo_index),
        .rdata (rs_rdata)
    );

    always_comb
    begin
        ws_we    = 1'b0;
        rs_we    = 1'b0;
        ws_waddr = {job_reg.combo_index, job_reg.action_index};
        rs_waddr = job_reg.combo_index;
        ws_wdata = sat_add(ws_reg, acc_reg[SUM_W+15:16]);
        rs_wdata = sat_add(rs_reg, p_reg);
        if (clearing)
        begin
            // zero both stores after reset
            ws_we    = 1'b1;
            rs_we    = 1'b1;
            ws_waddr = clr_reg[SLOT_W-1:0];
            rs_waddr = clr_reg[COMBO_W-1:0];
            ws_wdata = '0;
            rs_wdata = '0;
        end
        else if (state_reg == B_WR)
        begin
            ws_we = 1'b1;
            rs_we = (job_reg.action_index == '0);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clearing ? clr_reg + 1'b1 : clr_reg;
        job_next        = job_reg;
        ws_next         = ws_reg;
        rs_next         = rs_reg;
        p_next          = p_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        cnt_next        = cnt_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        res_status_next = res_status_reg;
        res_avg_next    = res_avg_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_avg_next    = out_avg_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    job_next        = pop_job;
                    res_status_next = pop_job.status;
                    res_avg_next    = '0;
                    state_next      = (pop_job.status == ST_DONE) ? B_RD : B_FIN;
                end
            end
            B_RD:
            begin
                ws_next = ws_rdata;
                rs_next = rs_rdata;
                if (job_reg.opcode == OP_READ)
                begin
                    if (rs_rdata == '0)
                    begin
                        res_avg_next = job_reg.uniform_prob;
                        state_next   = B_FIN;
                    end
                    else if (ws_rdata >= rs_rdata)
                    begin
                        res_avg_next = ONE_Q16;
                        state_next   = B_FIN;
                    end
                    else
                    begin
                        rem_next   = ws_rdata;
                        quo_next   = '0;
                        cnt_next   = 5'd16;
                        state_next = B_DIV;
                    end
                end
                else
                begin
                    acc_next    = '0;
                    mcand_next  = ACC_W'(job_reg.eff_weight);
                    mplier_next = job_reg.reach_prob;
                    cnt_next    = 5'(PROB_W);
                    state_next  = B_MUL1;
                end
            end
            B_MUL1, B_MUL2:
            begin
                // shift-add, one multiplier bit per cycle
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[PROB_W-1:1]};
                cnt_next    = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    if (state_reg == B_MUL1)
                    begin
                        p_next      = acc_next[SUM_W-1:0];
                        acc_next    = '0;
                        mcand_next  = ACC_W'(p_next);
                        mplier_next = job_reg.strategy_prob;
                        cnt_next    = 5'(PROB_W);
                        state_next  = B_MUL2;
                    end
                    else
                    begin
                        state_next = B_WR;
                    end
                end
            end
            B_WR:
            begin
                state_next = B_FIN;
            end
            B_DIV:
            begin
                if (rem_sh >= {1'b0, rs_reg})
                begin
                    rem_next = SUM_W'(rem_sh - {1'b0, rs_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[SUM_W-1:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    res_avg_next = {1'b0, quo_next};
                    state_next   = B_FIN;
                end
            end
            B_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_avg_next    = res_avg_reg;
                    state_next      = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_avg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        ws_reg         <= ws_next;
        rs_reg         <= rs_next;
        p_reg          <= p_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        cnt_reg        <= cnt_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        res_status_reg <= res_status_next;
        res_avg_reg    <= res_avg_next;
        out_status_reg <= out_status_next;
        out_avg_reg    <= out_avg_next;
    end
endmodule

// ===== sv/weighted_strategy_averager_core.sv =====
// Top level of the weighted strategy averager: config registers, front, queue, back.
//
// Items enter on the s_ side: s_tuser carries the opcode, s_tdata the addressed
// entry and operands. One result per item leaves on the m_ side: m_tuser is the
// status, m_tdata the Q1.16 average for a finalize read (zero otherwise).
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data while idle:
// the user is bound to that, and the block leaves it unenforced. The front end
// checks each item; an importance accumulate adds a serial restoring divide. Jobs
// then wait in a four-entry queue. The back end handles one job at a time: a
// rejected or skipped item goes straight to the result, a read is settled directly
// or by a 16-step divide, an accumulate runs two 17-step shift-add multiplies and
// a read-modify-write of the 64-bit sums. The back end's serial multiplier sets
// the sustained rate for plain and delayed accumulates; the front divide limits
// importance accumulates. After reset both sum stores are cleared, one slot per
// cycle; no item is accepted during that pass. A stalled receiver holds the result
// register; the front keeps accepting until the queue fills.
module weighted_strategy_averager_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // combo_index, action_index, strategy_prob, reach_prob, weight,
    // sampling_prob, iteration
    input  logic [135:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // average_prob
    output logic [23:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import wsa_pkg::*;

    wsa_cfg_t cfg_reg, cfg_next;
    logic     clearing;
    logic     push_valid, push_ready, pop_valid, pop_ready;
    wsa_job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIONS: cfg_next.actions_in_use   = cfg_data[3:0];
                CFG_COMBOS:  cfg_next.combos_in_use    = cfg_data[11:0];
                CFG_DELAY:   cfg_next.delay_iterations = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.actions_in_use   <= 4'd1;
            cfg_reg.combos_in_use    <= 12'd1;
            cfg_reg.delay_iterations <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    wsa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    wsa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );
endmodule

// ===== verif/weighted_strategy_averager_core_test.sv =====
// Stream testbench for the weighted strategy averager core with a self-checking predictor.
`timescale 1ns / 1ps

module weighted_strategy_averager_core_test;
    import wsa_pkg::*;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [10:0] combo_index;
        logic [2:0]  action_index;
        logic [16:0] strategy_prob;
        logic [16:0] reach_prob;
        logic [31:0] weight;
        logic [16:0] sampling_prob;
        logic [31:0] iteration;
    } element_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] average_prob;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 100000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    weighted_strategy_averager_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    logic [63:0] strat_sum [SLOT_DEPTH];
    logic [63:0] reach_sum [MAX_COMBOS];
    logic [3:0]  act_cfg;
    logic [11:0] combo_cfg;
    logic [31:0] delay_cfg;

    element_t    pending_items [$];
    outcome_t    expected_outcomes [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          mismatches;
    int          results_seen;
    int          idle_cycles;
    int          reads_seen;
    int          skips_seen;
    int          rejects_seen;

    always #5 clk = ~clk;

    // Apply one item to the predictor and return the result it produces.
    function automatic outcome_t accumulate_element(element_t e);
        outcome_t    r;
        logic [47:0] w;
        logic [63:0] p;
        logic [63:0] inc;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [16:0] q;
        logic        carry;
        int          slot;
        r.status = ST_REJECT;
        r.average_prob = '0;
        w = '0;
        if (e.opcode == OP_DELAYED)
        begin
            if (e.iteration == 0)
                return r;
            if (e.iteration <= delay_cfg)
            begin
                r.status = ST_SKIP;
                return r;
            end
            w = {16'd0, e.iteration - delay_cfg} << 16;
        end
        if (act_cfg == 0 || act_cfg > MAX_ACTIONS || combo_cfg == 0 || combo_cfg > MAX_COMBOS)
            return r;
        if (e.combo_index >= combo_cfg || e.action_index >= act_cfg)
            return r;
        slot = e.combo_index * MAX_ACTIONS + e.action_index;
        if (e.opcode == OP_READ)
        begin
            num = strat_sum[slot];
            den = reach_sum[e.combo_index];
            if (den == 0)
                r.average_prob = 17'(65536 / act_cfg);
            else if (num >= den)
                r.average_prob = ONE_Q16;
            else
            begin
                rem = num;
                q = '0;
                for (int i = 0; i < 16; i++)
                begin
                    carry = rem[63];
                    rem = rem << 1;
                    q = q << 1;
                    if (carry || rem >= den)
                    begin
                        rem = rem - den;
                        q[0] = 1'b1;
                    end
                end
                r.average_prob = q;
            end
            r.status = ST_DONE;
            return r;
        end
        if (e.strategy_prob > ONE_Q16 || e.reach_prob > ONE_Q16)
            return r;
        if (e.opcode == OP_PLAIN)
            w = {16'd0, e.weight};
        else if (e.opcode == OP_IMPORTANCE)
        begin
            if (e.sampling_prob == 0 || e.sampling_prob > ONE_Q16)
                return r;
            w = 48'(({16'd0, e.weight} << 16) / e.sampling_prob);
        end
        p = 64'(e.reach_prob) * 64'(w);
        inc = 64'(e.strategy_prob) * (p >> 16)
            + ((64'(e.strategy_prob) * (p & 64'hFFFF)) >> 16);
        if (e.action_index == 0)
            reach_sum[e.combo_index] = sat_add(reach_sum[e.combo_index], p);
        strat_sum[slot] = sat_add(strat_sum[slot], inc);
        r.status = ST_DONE;
        return r;
    endfunction

    // Driver: present items from the pending queue, idling at random.
    // Predict on acceptance, before the accepted item leaves the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_outcomes.push_back(accumulate_element(pending_items[0]));
                void'(pending_items.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    element_t nx;
                    nx = pending_items[0];
                    s_tvalid <= 1'b1;
                    s_tuser  <= nx.opcode;
                    s_tdata  <= {nx.iteration, nx.sampling_prob, nx.weight,
                                 nx.reach_prob, nx.strategy_prob,
                                 nx.action_index, nx.combo_index};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure, with an optional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            outcome_t want;
            results_seen <= results_seen + 1;
            if (expected_outcomes.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected item: status %0d avg %0d", m_tuser, m_tdata);
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (want.status == ST_SKIP)
                    skips_seen <= skips_seen + 1;
                if (want.status == ST_REJECT)
                    rejects_seen <= rejects_seen + 1;
                if (want.status == ST_DONE && want.average_prob != 0)
                    reads_seen <= reads_seen + 1;
                if (m_tuser != want.status || m_tdata != {7'd0, want.average_prob})
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: status exp %0d got %0d, avg exp %0d got %0d",
                                 want.status, m_tuser, want.average_prob, m_tdata);
                end
            end
        end
    end

    // Watchdog over cycles with no accepted item anywhere.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("weighted_strategy_averager_core test failed");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ACTIONS)
            act_cfg = val[3:0];
        else if (idx == CFG_COMBOS)
            combo_cfg = val[11:0];
        else
            delay_cfg = val;
    endtask

    task automatic drain_outputs();
        while (pending_items.size() != 0 || expected_outcomes.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [16:0] pick_prob();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return ONE_Q16;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic element_t random_element(int combo_span, int action_span);
        element_t e;
        e.opcode        = 2'($urandom_range(3));
        e.combo_index   = 11'($urandom_range(combo_span - 1));
        e.action_index  = 3'($urandom_range(action_span - 1));
        if ($urandom_range(19) == 0)
        begin
            e.combo_index  = 11'($urandom);
            e.action_index = 3'($urandom);
        end
        e.strategy_prob = pick_prob();
        e.reach_prob    = pick_prob();
        e.sampling_prob = pick_prob();
        e.weight        = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1 << 18);
        if ($urandom_range(15) == 0)
            e.iteration = '0;
        else if ($urandom_range(7) == 0)
            e.iteration = $urandom;
        else
            e.iteration = delay_cfg + $urandom_range(40) - 5;
        return e;
    endfunction

    function automatic element_t make_element(logic [1:0] op, int c, int a, int sp, int rp,
                                              logic [31:0] w, int smp, logic [31:0] it);
        element_t e;
        e.opcode = op; e.combo_index = 11'(c); e.action_index = 3'(a);
        e.strategy_prob = 17'(sp); e.reach_prob = 17'(rp); e.weight = w;
        e.sampling_prob = 17'(smp); e.iteration = it;
        return e;
    endfunction

    initial
    begin
        int          acts;
        int          combos;
        logic [31:0] delays [4];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ACTIONS;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        idle_cycles = 0;
        reads_seen = 0;
        skips_seen = 0;
        rejects_seen = 0;
        act_cfg = 4'd1;
        combo_cfg = 12'd1;
        delay_cfg = '0;
        for (int i = 0; i < SLOT_DEPTH; i++)
            strat_sum[i] = '0;
        for (int i = 0; i < MAX_COMBOS; i++)
            reach_sum[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset config, then a small config with every operation and corner
        pending_items.push_back(make_element(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_element(OP_PLAIN, 0, 0, 65536, 65536, 32'hFFFFFFFF, 0, 0));
        pending_items.push_back(make_element(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_element(OP_DELAYED, 0, 0, 65536, 65536, 0, 0, 0));
        drain_outputs();
        write_register(CFG_ACTIONS, 4);
        write_register(CFG_COMBOS, 3);
        write_register(CFG_DELAY, 5);
        pending_items.push_back(make_element(OP_READ, 1, 2, 0, 0, 0, 0, 0));
        pending_items.push_back(make_element(OP_DELAYED, 1, 0, 30000, 40000, 0, 0, 5));
        pending_items.push_back(make_element(OP_DELAYED, 1, 0, 30000, 40000, 0, 0, 6));
        pending_items.push_back(make_element(OP_DELAYED, 1, 1, 65536, 65536, 0, 0,
                                             32'hFFFFFFFF));
        pending_items.push_back(make_element(OP_IMPORTANCE, 1, 2, 1000, 2000, 777, 0, 0));
        pending_items.push_back(make_element(OP_IMPORTANCE, 1, 2, 1000, 2000, 777, 65537, 0));
        pending_items.push_back(make_element(OP_IMPORTANCE, 1, 2, 1000, 2000, 32'hFFFFFFFF,
                                             1, 0));
        pending_items.push_back(make_element(OP_PLAIN, 1, 3, 65537, 100, 5, 0, 0));
        pending_items.push_back(make_element(OP_PLAIN, 1, 3, 100, 131071, 5, 0, 0));
        pending_items.push_back(make_element(OP_PLAIN, 3, 0, 100, 100, 5, 0, 0));
        pending_items.push_back(make_element(OP_PLAIN, 2, 4, 100, 100, 5, 0, 0));
        pending_items.push_back(make_element(OP_PLAIN, 2047, 7, 100, 100, 5, 131071, 0));
        for (int a = 0; a < 4; a++)
            pending_items.push_back(make_element(OP_READ, 1, a, 0, 0, 0, 0, 0));
        drain_outputs();
        write_register(CFG_ACTIONS, 0);
        pending_items.push_back(make_element(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        drain_outputs();
        write_register(CFG_ACTIONS, 9);
        write_register(CFG_COMBOS, 4095);
        pending_items.push_back(make_element(OP_PLAIN, 0, 0, 1, 1, 1, 0, 0));
        drain_outputs();

        // Random phases over settings and idling mixes
        delays[0] = 0; delays[1] = 5; delays[2] = 1000; delays[3] = 32'hFFFFFFF0;
        for (int ph = 0; ph < 8; ph++)
        begin
            acts = (ph == 0) ? 1 : (ph == 7) ? 8 : $urandom_range(1, 8);
            combos = (ph == 3) ? 2048 : (ph == 0) ? 1 : $urandom_range(2, 6);
            write_register(CFG_ACTIONS, acts);
            write_register(CFG_COMBOS, combos);
            write_register(CFG_DELAY, delays[ph % 4]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int i = 0; i < 210; i++)
            begin
                pending_items.push_back(random_element(combos + 1, acts + 1));
                if (ph == 2 && i == 20)
                    hold_off_cycles = 600;
                if (i == 100)
                    drain_outputs();
            end
            drain_outputs();
        end

        $display("covered %0d results: %0d nonzero reads, %0d skips, %0d rejections",
                 results_seen, reads_seen, skips_seen, rejects_seen);
        $display("configurations from one action and combo up to full size and extreme delays");
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("weighted_strategy_averager_core test passed");
        else
            $display("weighted_strategy_averager_core test failed");
        $finish;
    end

endmodule
